// File: rtl/ljpe_pkg.sv
// Lennard-Jones pair energy: shared types, codes and constant tables.
// Used by lennard_jones_pair_energy_core. No dependencies.
package ljpe_pkg;

   // model modes
   localparam logic [1:0] MODE_BIN2D  = 2'd0;
   localparam logic [1:0] MODE_SMOOTH = 2'd1;
   localparam logic [1:0] MODE_PLAIN  = 2'd2;
   localparam logic [1:0] MODE_POLY   = 2'd3;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_C0     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_C2     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_C4     = 3'd4;

   // register reset values
   localparam logic [1:0]  MODE_RST   = MODE_SMOOTH;
   localparam logic [31:0] CUTOFF_RST = 32'd419430400;

   // polydisperse factor: 0.2 as 13107/65536, one in Q.28
   localparam logic [29:0] POLY_K  = 30'd13107;
   localparam logic [29:0] ONE_Q28 = 30'h1000_0000;

   // reduced distance limit for the very close pair, 1/16 in Q.32
   localparam logic [38:0] RR_CLOSE = 39'h10000000;

   // energy range, signed Q24.16
   localparam logic [39:0] ENERGY_MAX = 40'h7F_FFFF_FFFF;
   localparam logic [39:0] ENERGY_MIN = 40'h80_0000_0000;

   typedef struct packed {
      logic [31:0] dist_sq;
      logic [1:0]  type_a;
      logic [1:0]  type_b;
      logic [15:0] diameter_a;
      logic [15:0] diameter_b;
   } req_type;

   typedef struct packed {
      logic [39:0] energy;
      logic        inside_cutoff;
      logic        saturated;
   } rsp_type;

   // sideband through the distance divider
   typedef struct packed {
      logic [2:0] e4;
      logic       bad;
      logic       in_plain;
      logic       ovf;
   } div1_side_type;

   // sideband through the reciprocal divider
   typedef struct packed {
      logic [2:0]  e4;
      logic        in_cut;
      logic        close;
      logic [30:0] rq;
      logic [37:0] rq2;
   } div2_side_type;

   // sigma in Q.24; grp 0 is the 2D mixture, grp 1 the other table modes
   function automatic logic [24:0] sigma_lookup(input logic grp, input logic [1:0] ta,
                                                input logic [1:0] tb);
      logic [24:0] v;
      v = '0;
      case ({ta, tb}) inside
         4'b0000:          v = 25'd16777216;
         4'b0001, 4'b0100: v = 25'd13421773;
         4'b0010, 4'b1000: v = 25'd15099494;
         4'b0101:          v = 25'd14763950;
         4'b0110, 4'b1001: v = grp ? 25'd14092861 : 25'd13421773;
         4'b1010:          v = 25'd15770583;
         default:          v = '0;
      endcase
      return v;
   endfunction

   // four times epsilon, exact
   function automatic logic [2:0] eps4_lookup(input logic grp, input logic [1:0] ta,
                                              input logic [1:0] tb);
      logic [2:0] v;
      v = '0;
      case ({ta, tb}) inside
         4'b0000:          v = 3'd4;
         4'b0001, 4'b0100: v = 3'd6;
         4'b0010, 4'b1000: v = grp ? 3'd5 : 3'd3;
         4'b0101:          v = 3'd2;
         4'b0110, 4'b1001: v = grp ? 3'd4 : 3'd6;
         4'b1010:          v = 3'd3;
         default:          v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/lennard_jones_pair_energy_core.sv
// Lennard-Jones pair energy core, fixed point, fully pipelined.
// Depends on ljpe_pkg and ljpe_pipe_div.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  ljpe_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready  ljpe_pkg::rsp_type
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One pair per cycle while rsp is not stalled. The two dividers are pipelined,
// with B = BITS_PER_STAGE quotient bits per divider stage.
// Synchronous reset clears the stage valid bits and loads the register defaults.
// A stalled rsp freezes the whole pipeline; req_ready falls with it.
// csr_ready is always high; writes to unknown indexes are dropped.
module lennard_jones_pair_energy_core #(
   parameter int BITS_PER_STAGE = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ljpe_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ljpe_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ljpe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                      csr_data
);

   logic adv;

   // configuration registers
   logic [1:0]  mode_ff;
   logic [31:0] cutoff_ff;
   logic [31:0] c0_ff;
   logic [31:0] c2_ff;
   logic [31:0] c4_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ljpe_pkg::MODE_RST;
         cutoff_ff <= ljpe_pkg::CUTOFF_RST;
         c0_ff     <= '0;
         c2_ff     <= '0;
         c4_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            ljpe_pkg::CSR_MODE:   mode_ff   <= csr_data[1:0];
            ljpe_pkg::CSR_CUTOFF: cutoff_ff <= csr_data;
            ljpe_pkg::CSR_C0:     c0_ff     <= csr_data;
            ljpe_pkg::CSR_C2:     c2_ff     <= csr_data;
            ljpe_pkg::CSR_C4:     c4_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline advances unless the output holds an untaken transaction
   logic p6_valid_ff;
   assign adv       = !p6_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 0: table lookup, polydisperse factor
   logic [15:0] diff_w;
   logic [29:0] kd_w;
   logic [29:0] fmag_w;
   logic        poly_w;
   logic        grp_w;

   assign poly_w = (mode_ff == ljpe_pkg::MODE_POLY);
   assign grp_w  = (mode_ff != ljpe_pkg::MODE_BIN2D);
   assign diff_w = (req_data.diameter_a >= req_data.diameter_b) ?
                   req_data.diameter_a - req_data.diameter_b :
                   req_data.diameter_b - req_data.diameter_a;
   assign kd_w   = 30'(diff_w) * ljpe_pkg::POLY_K;
   assign fmag_w = (kd_w <= ljpe_pkg::ONE_Q28) ? ljpe_pkg::ONE_Q28 - kd_w
                                               : kd_w - ljpe_pkg::ONE_Q28;

   logic        s0_valid_ff;
   logic [31:0] s0_dist_ff;
   logic [16:0] s0_sum_ff;
   logic [29:0] s0_fmag_ff;
   logic [24:0] s0_tsig_ff;
   logic [2:0]  s0_e4_ff;
   logic        s0_bad_ff;
   logic        s0_plain_ff;
   logic        s0_poly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_dist_ff  <= req_data.dist_sq;
         s0_sum_ff   <= 17'(req_data.diameter_a) + 17'(req_data.diameter_b);
         s0_fmag_ff  <= fmag_w;
         s0_tsig_ff  <= ljpe_pkg::sigma_lookup(grp_w, req_data.type_a, req_data.type_b);
         s0_e4_ff    <= poly_w ? 3'd4 :
                        ljpe_pkg::eps4_lookup(grp_w, req_data.type_a, req_data.type_b);
         s0_bad_ff   <= !poly_w && (req_data.type_a > 2'd2 || req_data.type_b > 2'd2);
         s0_plain_ff <= req_data.dist_sq < cutoff_ff;
         s0_poly_ff  <= poly_w;
      end
   end

   // ---------------- stage 1: sigma
   logic [46:0] sprod_w;
   assign sprod_w = 47'(s0_sum_ff) * 47'(s0_fmag_ff);

   logic        s1_valid_ff;
   logic [31:0] s1_dist_ff;
   logic [29:0] s1_sig_ff;
   logic [2:0]  s1_e4_ff;
   logic        s1_bad_ff;
   logic        s1_plain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_dist_ff  <= s0_dist_ff;
         s1_sig_ff   <= s0_poly_ff ? sprod_w[46:17] : 30'(s0_tsig_ff);
         s1_e4_ff    <= s0_e4_ff;
         s1_bad_ff   <= s0_bad_ff;
         s1_plain_ff <= s0_plain_ff;
      end
   end

   // ---------------- stage 2: sigma squared
   logic [59:0] sq_w;
   assign sq_w = 60'(s1_sig_ff) * 60'(s1_sig_ff);

   logic        s2_valid_ff;
   logic [31:0] s2_dist_ff;
   logic [35:0] s2_sig2_ff;
   logic [2:0]  s2_e4_ff;
   logic        s2_bad_ff;
   logic        s2_plain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_dist_ff  <= s1_dist_ff;
         s2_sig2_ff  <= sq_w[59:24];
         s2_e4_ff    <= s1_e4_ff;
         s2_bad_ff   <= s1_bad_ff;
         s2_plain_ff <= s1_plain_ff;
      end
   end

   // ---------------- reduced distance rr = (dist << 30) / sig2, 39 bits
   ljpe_pkg::div1_side_type d1_in_side;
   ljpe_pkg::div1_side_type d1_out_side;
   logic [35:0]             d1_rem0;
   logic                    d1_valid;
   logic [38:0]             rr_w;

   assign d1_rem0              = 36'(s2_dist_ff[31:9]);
   assign d1_in_side.e4        = s2_e4_ff;
   assign d1_in_side.bad       = s2_bad_ff || (s2_sig2_ff == '0);
   assign d1_in_side.in_plain  = s2_plain_ff;
   // quotient would not fit in 39 bits: far outside any cutoff
   assign d1_in_side.ovf       = (d1_rem0 >= s2_sig2_ff);

   ljpe_pipe_div #(
      .DEN_W     (36),
      .QUO_W     (39),
      .SIDE_W    ($bits(ljpe_pkg::div1_side_type)),
      .STEP_BITS (BITS_PER_STAGE)
   ) u_div_rr (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s2_valid_ff),
      .in_rem    (d1_rem0),
      .in_den    (s2_sig2_ff),
      .in_num    ({s2_dist_ff[8:0], 30'b0}),
      .in_side   (d1_in_side),
      .out_valid (d1_valid),
      .out_quo   (rr_w),
      .out_side  (d1_out_side)
   );

   // ---------------- stage A: cutoff test, rq and rq^2
   logic        inside_w;
   logic [61:0] rqsq_w;

   assign inside_w = !d1_out_side.bad &&
                     ((mode_ff == ljpe_pkg::MODE_PLAIN) ? d1_out_side.in_plain :
                      (!d1_out_side.ovf && (rr_w < 39'({cutoff_ff, 6'b0}))));
   assign rqsq_w   = 62'(rr_w[38:8]) * 62'(rr_w[38:8]);

   logic          sa_valid_ff;
   logic [38:0]   sa_rr_ff;
   ljpe_pkg::div2_side_type sa_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else if (adv) begin
         sa_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_rr_ff          <= rr_w;
         sa_side_ff.e4     <= d1_out_side.e4;
         sa_side_ff.in_cut <= inside_w;
         sa_side_ff.close  <= rr_w <= ljpe_pkg::RR_CLOSE;
         sa_side_ff.rq     <= rr_w[38:8];
         sa_side_ff.rq2    <= rqsq_w[61:24];
      end
   end

   // ---------------- reciprocal inv = 2^56 / rr, 28 bits
   ljpe_pkg::div2_side_type d2_side;
   logic                    d2_valid;
   logic [27:0]             inv_w;

   ljpe_pipe_div #(
      .DEN_W     (39),
      .QUO_W     (28),
      .SIDE_W    ($bits(ljpe_pkg::div2_side_type)),
      .STEP_BITS (BITS_PER_STAGE)
   ) u_div_inv (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sa_valid_ff),
      .in_rem    (ljpe_pkg::RR_CLOSE),
      .in_den    (sa_rr_ff),
      .in_num    (28'b0),
      .in_side   (sa_side_ff),
      .out_valid (d2_valid),
      .out_quo   (inv_w),
      .out_side  (d2_side)
   );

   // ---------------- P1: inv^2, coefficient products
   logic [55:0] isq_w;
   logic [31:0] c2m_w;
   logic [31:0] c4m_w;

   assign isq_w = 56'(inv_w) * 56'(inv_w);
   assign c2m_w = c2_ff[31] ? 32'd0 - c2_ff : c2_ff;
   assign c4m_w = c4_ff[31] ? 32'd0 - c4_ff : c4_ff;

   logic        p1_valid_ff;
   logic [27:0] p1_inv_ff;
   logic [31:0] p1_inv2_ff;
   logic [62:0] p1_p2_ff;
   logic [50:0] p1_p4l_ff;
   logic [50:0] p1_p4h_ff;
   logic [2:0]  p1_e4_ff;
   logic        p1_inside_ff;
   logic        p1_close_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_inv_ff    <= inv_w;
         p1_inv2_ff   <= isq_w[55:24];
         p1_p2_ff     <= 63'(c2m_w) * 63'(d2_side.rq);
         p1_p4l_ff    <= 51'(c4m_w) * 51'(d2_side.rq2[18:0]);
         p1_p4h_ff    <= 51'(c4m_w) * 51'(d2_side.rq2[37:19]);
         p1_e4_ff     <= d2_side.e4;
         p1_inside_ff <= d2_side.in_cut;
         p1_close_ff  <= d2_side.close;
      end
   end

   // ---------------- P2: r6, signed smoothing terms
   logic [59:0]        cube_w;
   logic [69:0]        p4s_w;
   logic signed [39:0] t2_w;
   logic signed [46:0] t4_w;

   assign cube_w = 60'(p1_inv2_ff) * 60'(p1_inv_ff);
   assign p4s_w  = {p1_p4h_ff, 19'b0} + 70'(p1_p4l_ff);
   assign t2_w   = c2_ff[31] ? 40'd0 - 40'(p1_p2_ff[62:24]) : 40'(p1_p2_ff[62:24]);
   assign t4_w   = c4_ff[31] ? 47'd0 - 47'(p4s_w[69:24]) : 47'(p4s_w[69:24]);

   logic               p2_valid_ff;
   logic [35:0]        p2_r6_ff;
   logic signed [39:0] p2_t2_ff;
   logic signed [46:0] p2_t4_ff;
   logic [2:0]         p2_e4_ff;
   logic               p2_inside_ff;
   logic               p2_close_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_r6_ff     <= cube_w[59:24];
         p2_t2_ff     <= t2_w;
         p2_t4_ff     <= t4_w;
         p2_e4_ff     <= p1_e4_ff;
         p2_inside_ff <= p1_inside_ff;
         p2_close_ff  <= p1_close_ff;
      end
   end

   // ---------------- P3: r12 partial products, sum of the other terms
   logic signed [50:0] poly_sum_w;
   logic signed [50:0] base_w;

   assign poly_sum_w = 51'($signed(c0_ff)) + 51'(p2_t2_ff) + 51'(p2_t4_ff);
   assign base_w = ((mode_ff != ljpe_pkg::MODE_PLAIN) ? poly_sum_w : 51'sd0) -
                   ((mode_ff != ljpe_pkg::MODE_POLY) ? $signed(51'(p2_r6_ff)) : 51'sd0);

   logic               p3_valid_ff;
   logic [53:0]        p3_r12l_ff;
   logic [53:0]        p3_r12h_ff;
   logic signed [50:0] p3_base_ff;
   logic [2:0]         p3_e4_ff;
   logic               p3_inside_ff;
   logic               p3_close_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_r12l_ff   <= 54'(p2_r6_ff) * 54'(p2_r6_ff[17:0]);
         p3_r12h_ff   <= 54'(p2_r6_ff) * 54'(p2_r6_ff[35:18]);
         p3_base_ff   <= base_w;
         p3_e4_ff     <= p2_e4_ff;
         p3_inside_ff <= p2_inside_ff;
         p3_close_ff  <= p2_close_ff;
      end
   end

   // ---------------- P4: r12 and the term sum
   logic [71:0] r12s_w;
   assign r12s_w = {p3_r12h_ff, 18'b0} + 72'(p3_r12l_ff);

   logic               p4_valid_ff;
   logic signed [50:0] p4_s_ff;
   logic [2:0]         p4_e4_ff;
   logic               p4_inside_ff;
   logic               p4_close_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (adv) begin
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_s_ff      <= $signed(51'(r12s_w[71:24])) + p3_base_ff;
         p4_e4_ff     <= p3_e4_ff;
         p4_inside_ff <= p3_inside_ff;
         p4_close_ff  <= p3_close_ff;
      end
   end

   // ---------------- P5: scale by 4*eps
   logic signed [54:0] prod_w;
   assign prod_w = 55'(p4_s_ff) * $signed(55'(p4_e4_ff));

   logic               p5_valid_ff;
   logic signed [54:0] p5_prod_ff;
   logic               p5_inside_ff;
   logic               p5_close_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else if (adv) begin
         p5_valid_ff <= p4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_prod_ff   <= prod_w;
         p5_inside_ff <= p4_inside_ff;
         p5_close_ff  <= p4_close_ff;
      end
   end

   // ---------------- P6: truncate toward zero, saturate, output register
   logic [54:0]       mag_w;
   logic [46:0]       sh_w;
   ljpe_pkg::rsp_type res_w;
   ljpe_pkg::rsp_type rsp_ff;

   assign mag_w = p5_prod_ff[54] ? 55'd0 - 55'(p5_prod_ff) : 55'(p5_prod_ff);
   assign sh_w  = mag_w[54:8];

   always_comb begin
      res_w.energy        = '0;
      res_w.inside_cutoff = 1'b0;
      res_w.saturated     = 1'b0;
      if (p5_inside_ff) begin
         res_w.inside_cutoff = 1'b1;
         if (p5_close_ff) begin
            res_w.energy    = ljpe_pkg::ENERGY_MAX;
            res_w.saturated = 1'b1;
         end else if (p5_prod_ff[54]) begin
            if (sh_w > 47'(ljpe_pkg::ENERGY_MIN)) begin
               res_w.energy    = ljpe_pkg::ENERGY_MIN;
               res_w.saturated = 1'b1;
            end else begin
               res_w.energy = 40'd0 - sh_w[39:0];
            end
         end else begin
            if (sh_w > 47'(ljpe_pkg::ENERGY_MAX)) begin
               res_w.energy    = ljpe_pkg::ENERGY_MAX;
               res_w.saturated = 1'b1;
            end else begin
               res_w.energy = sh_w[39:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_valid_ff <= 1'b0;
      end else if (adv) begin
         p6_valid_ff <= p5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= res_w;
      end
   end

   assign rsp_valid = p6_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/ljpe_pipe_div.sv
// Pipelined restoring divider, STEP_BITS quotient bits per register stage.
// Carries a valid bit and a sideband vector. Used by the core; no package use.
module ljpe_pipe_div #(
   parameter int DEN_W     = 36,
   parameter int QUO_W     = 39,
   parameter int SIDE_W    = 6,
   parameter int STEP_BITS = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DEN_W-1:0]  in_rem,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [QUO_W-1:0]  in_num,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int STAGES = (QUO_W + STEP_BITS - 1) / STEP_BITS;

   logic [STAGES-1:0] vld_ff;
   logic [DEN_W-1:0]  rem_ff  [STAGES];
   logic [DEN_W-1:0]  den_ff  [STAGES];
   // dividend bits leave at the top, quotient bits enter at the bottom
   logic [QUO_W-1:0]  nq_ff   [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int FIRST = s * STEP_BITS;
      localparam int NB = (QUO_W - FIRST < STEP_BITS) ? (QUO_W - FIRST) : STEP_BITS;

      logic              src_vld;
      logic [DEN_W-1:0]  src_rem;
      logic [DEN_W-1:0]  src_den;
      logic [QUO_W-1:0]  src_nq;
      logic [SIDE_W-1:0] src_side;
      logic [DEN_W-1:0]  rem_in;
      logic [QUO_W-1:0]  nq_in;
      logic [DEN_W:0]    trial;

      if (s == 0) begin : g_src_in
         assign src_vld  = in_valid;
         assign src_rem  = in_rem;
         assign src_den  = in_den;
         assign src_nq   = in_num;
         assign src_side = in_side;
      end else begin : g_src_prev
         assign src_vld  = vld_ff[s-1];
         assign src_rem  = rem_ff[s-1];
         assign src_den  = den_ff[s-1];
         assign src_nq   = nq_ff[s-1];
         assign src_side = side_ff[s-1];
      end

      // NB compare-and-subtract steps
      always_comb begin
         rem_in = src_rem;
         nq_in  = src_nq;
         trial  = '0;
         for (int b = 0; b < NB; b++) begin
            trial = {rem_in, nq_in[QUO_W-1]};
            nq_in = {nq_in[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, src_den}) begin
               trial    = trial - {1'b0, src_den};
               nq_in[0] = 1'b1;
            end
            rem_in = trial[DEN_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= src_den;
            nq_ff[s]   <= nq_in;
            side_ff[s] <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_quo   = nq_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule
